FILE: rtl/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
package ps2mt_pkg;

   localparam int unsigned POS_W  = 12;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned MAG_W  = 9;
   localparam int unsigned SUM_W  = POS_W + 2;

   // Header byte bit positions
   localparam int unsigned HDR_BTN_LEFT   = 0;
   localparam int unsigned HDR_BTN_RIGHT  = 1;
   localparam int unsigned HDR_BTN_MIDDLE = 2;
   localparam int unsigned HDR_SYNC       = 3;
   localparam int unsigned HDR_X_SIGN     = 4;
   localparam int unsigned HDR_Y_SIGN     = 5;
   localparam int unsigned HDR_X_OVF      = 6;
   localparam int unsigned HDR_Y_OVF      = 7;

   localparam logic [MAG_W-1:0] OVF_EXTRA = 9'd255;

   localparam logic [POS_W-1:0] X_LIMIT_RESET = 12'd1919;
   localparam logic [POS_W-1:0] Y_LIMIT_RESET = 12'd1079;

   // Register indexes
   localparam logic CSR_X_LIMIT = 1'b0;
   localparam logic CSR_Y_LIMIT = 1'b1;

   typedef struct packed {
      logic              complete;   // current byte closes a packet
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_byte;
   } frame_type;

endpackage

FILE: rtl/ps2mt_framer.sv
// Byte framer: finds a header and collects the header and X bytes of a packet.
module ps2mt_framer
   import ps2mt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] packet_byte,
   output frame_type         frame
);

   localparam logic [1:0] PHASE_HDR = 2'd0;
   localparam logic [1:0] PHASE_X   = 2'd1;
   localparam logic [1:0] PHASE_Y   = 2'd2;
   localparam logic [1:0] PHASE_BAD = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] x_byte_ff, x_byte_in;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      x_byte_in = x_byte_ff;
      if (accept) begin
         unique case (phase_ff)
            PHASE_X: begin
               x_byte_in = packet_byte;
               phase_in  = PHASE_Y;
            end
            PHASE_Y: begin
               phase_in = PHASE_HDR;
            end
            PHASE_HDR, PHASE_BAD: begin
               // drop bytes until one carries the sync bit
               if (packet_byte[HDR_SYNC]) begin
                  header_in = packet_byte;
                  phase_in  = PHASE_X;
               end else begin
                  phase_in = PHASE_HDR;
               end
            end
            default: phase_in = PHASE_HDR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HDR;
      end else begin
         phase_ff <= phase_in;
      end
      header_ff <= header_in;
      x_byte_ff <= x_byte_in;
   end

   assign frame.complete = (phase_ff == PHASE_Y);
   assign frame.header   = header_ff;
   assign frame.x_byte   = x_byte_ff;

endmodule

FILE: rtl/ps2mt_axis.sv
// One cursor axis: holds the position, applies a move and clamps it.
module ps2mt_axis
   import ps2mt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  logic [BYTE_W-1:0] delta_byte,
   input  logic              sign,
   input  logic              overflow,
   input  logic              subtract,
   input  logic [POS_W-1:0]  limit,
   output logic [POS_W-1:0]  position,
   output logic [POS_W-1:0]  next_position
);

   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [BYTE_W-1:0] base_mag;
   logic [MAG_W-1:0]  magnitude;
   logic [SUM_W-1:0]  sum;

   always_comb begin
      // a set sign bit means (256 - byte) mod 256 the other way
      base_mag  = sign ? (~delta_byte + 8'd1) : delta_byte;
      magnitude = {1'b0, base_mag} + (overflow ? OVF_EXTRA : '0);
      if (subtract) begin
         sum = {2'b00, cursor_ff} - {{(SUM_W-MAG_W){1'b0}}, magnitude};
      end else begin
         sum = {2'b00, cursor_ff} + {{(SUM_W-MAG_W){1'b0}}, magnitude};
      end
      priority if (sum[SUM_W-1]) begin
         next_position = '0;
      end else if (sum[SUM_W-2:0] > {1'b0, limit}) begin
         next_position = limit;
      end else begin
         next_position = sum[POS_W-1:0];
      end
      cursor_in = update ? next_position : cursor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
   end

   assign position = cursor_ff;

endmodule

FILE: rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker.
// A packet's result appears in the cycle after its third byte transfers.
// Throughput: one byte per cycle; the input stalls only while a result is held
// in the output register and the consumer is not ready.
// Reset: synchronous, active high; awaits a header, cursor at 0,0, limits at
// 1919 and 1079, no result pending.
module ps2_mouse_packet_tracker
   import ps2mt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_packet_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_new_x,
   output logic [POS_W-1:0]  rsp_new_y,
   output logic [POS_W-1:0]  rsp_old_x,
   output logic [POS_W-1:0]  rsp_old_y,
   output logic              rsp_left_button,
   output logic              rsp_right_button,
   output logic              rsp_middle_button,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [POS_W-1:0]  csr_wdata
);

   frame_type        frame;
   logic             req_fire;
   logic             result_fire;
   logic [POS_W-1:0] x_limit_ff, x_limit_in;
   logic [POS_W-1:0] y_limit_ff, y_limit_in;
   logic [POS_W-1:0] cur_x, cur_y, next_x, next_y;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] new_x_ff, new_y_ff, old_x_ff, old_y_ff;
   logic [2:0]       buttons_ff;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign result_fire = req_fire && frame.complete;

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_X_LIMIT: x_limit_in = csr_wdata;
            CSR_Y_LIMIT: y_limit_in = csr_wdata;
            default:     x_limit_in = x_limit_ff;
         endcase
      end
   end

   ps2mt_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_fire),
      .packet_byte (req_packet_byte),
      .frame       (frame)
   );

   ps2mt_axis u_axis_x (
      .clock         (clock),
      .reset         (reset),
      .update        (result_fire),
      .delta_byte    (frame.x_byte),
      .sign          (frame.header[HDR_X_SIGN]),
      .overflow      (frame.header[HDR_X_OVF]),
      .subtract      (frame.header[HDR_X_SIGN]),
      .limit         (x_limit_ff),
      .position      (cur_x),
      .next_position (next_x)
   );

   // Y is inverted: screen Y grows downward
   ps2mt_axis u_axis_y (
      .clock         (clock),
      .reset         (reset),
      .update        (result_fire),
      .delta_byte    (req_packet_byte),
      .sign          (frame.header[HDR_Y_SIGN]),
      .overflow      (frame.header[HDR_Y_OVF]),
      .subtract      (!frame.header[HDR_Y_SIGN]),
      .limit         (y_limit_ff),
      .position      (cur_y),
      .next_position (next_y)
   );

   // hold a result until its transfer
   assign rsp_valid_in = result_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         x_limit_ff   <= X_LIMIT_RESET;
         y_limit_ff   <= Y_LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
      end
      if (result_fire) begin
         new_x_ff   <= next_x;
         new_y_ff   <= next_y;
         old_x_ff   <= cur_x;
         old_y_ff   <= cur_y;
         buttons_ff <= {frame.header[HDR_BTN_MIDDLE], frame.header[HDR_BTN_RIGHT],
                        frame.header[HDR_BTN_LEFT]};
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_x         = new_x_ff;
   assign rsp_new_y         = new_y_ff;
   assign rsp_old_x         = old_x_ff;
   assign rsp_old_y         = old_y_ff;
   assign rsp_left_button   = buttons_ff[0];
   assign rsp_right_button  = buttons_ff[1];
   assign rsp_middle_button = buttons_ff[2];

endmodule

FILE: rtl/ps2mt_checker.sv
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
module ps2mt_checker
   import ps2mt_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] rsp_new_x,
   input logic [POS_W-1:0] rsp_new_y,
   input logic [POS_W-1:0] rsp_old_x,
   input logic [POS_W-1:0] rsp_old_y
);

   logic [POS_W-1:0] last_x_ff, last_y_ff;

   // track the position left by the last transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_x_ff <= rsp_new_x;
         last_y_ff <= rsp_new_y;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_x) && $stable(rsp_new_y))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_old_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_old_x == last_x_ff && rsp_old_y == last_y_ff)
      else $error("old position does not match previous new position");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a held result");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_new_x (rsp_new_x),
   .rsp_new_y (rsp_new_y),
   .rsp_old_x (rsp_old_x),
   .rsp_old_y (rsp_old_y)
);

FILE: tb/ps2mt_checker.sv
// Scoreboard for the PS/2 mouse packet tracker: predicts cursor moves and checks each result.
module ps2mt_scoreboard
   import ps2mt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [BYTE_W-1:0] req_packet_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [POS_W-1:0]  rsp_new_x,
   input  logic [POS_W-1:0]  rsp_new_y,
   input  logic [POS_W-1:0]  rsp_old_x,
   input  logic [POS_W-1:0]  rsp_old_y,
   input  logic              rsp_left_button,
   input  logic              rsp_right_button,
   input  logic              rsp_middle_button,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [POS_W-1:0]  csr_wdata,
   output int unsigned       error_count,
   output int unsigned       moves_pending,
   output int unsigned       moves_checked
);

   typedef struct packed {
      logic [POS_W-1:0] new_x;
      logic [POS_W-1:0] new_y;
      logic [POS_W-1:0] old_x;
      logic [POS_W-1:0] old_y;
      logic             left_btn;
      logic             right_btn;
      logic             middle_btn;
   } cursor_move_type;

   typedef enum logic [1:0] {
      AWAIT_HEADER,
      AWAIT_X,
      AWAIT_Y
   } byte_phase_type;

   cursor_move_type   expected_moves[$];
   cursor_move_type   want;
   cursor_move_type   got;
   byte_phase_type    phase;
   logic [BYTE_W-1:0] header;
   logic [BYTE_W-1:0] x_byte;
   logic [POS_W-1:0]  cur_x;
   logic [POS_W-1:0]  cur_y;
   logic [POS_W-1:0]  lim_x;
   logic [POS_W-1:0]  lim_y;
   int unsigned       mismatches;
   int unsigned       checked;

   function automatic int step_size(input logic [BYTE_W-1:0] b, input logic neg,
                                    input logic ovf);
      int m;
      // a negative move is the two's complement magnitude, so zero stays zero
      m = neg ? ((256 - int'(b)) % 256) : int'(b);
      if (ovf)
         m = m + int'(OVF_EXTRA);
      return m;
   endfunction

   function automatic logic [POS_W-1:0] clamp_to(input int v, input logic [POS_W-1:0] lim);
      if (v < 0)
         return '0;
      if (v > int'(lim))
         return lim;
      return v[POS_W-1:0];
   endfunction

   function automatic void track_byte(input logic [BYTE_W-1:0] b);
      int              mx;
      int              my;
      int              nx;
      int              ny;
      cursor_move_type m;
      case (phase)
         AWAIT_X: begin
            x_byte = b;
            phase  = AWAIT_Y;
         end
         AWAIT_Y: begin
            mx = step_size(x_byte, header[HDR_X_SIGN], header[HDR_X_OVF]);
            my = step_size(b, header[HDR_Y_SIGN], header[HDR_Y_OVF]);
            m.old_x = cur_x;
            m.old_y = cur_y;
            nx = header[HDR_X_SIGN] ? int'(cur_x) - mx : int'(cur_x) + mx;
            // screen Y grows downward, so the mouse direction is inverted
            ny = header[HDR_Y_SIGN] ? int'(cur_y) + my : int'(cur_y) - my;
            cur_x = clamp_to(nx, lim_x);
            cur_y = clamp_to(ny, lim_y);
            m.new_x      = cur_x;
            m.new_y      = cur_y;
            m.left_btn   = header[HDR_BTN_LEFT];
            m.right_btn  = header[HDR_BTN_RIGHT];
            m.middle_btn = header[HDR_BTN_MIDDLE];
            expected_moves.push_back(m);
            phase = AWAIT_HEADER;
         end
         default: begin
            // drop anything without the sync bit while a header is awaited
            if (b[HDR_SYNC]) begin
               header = b;
               phase  = AWAIT_X;
            end else begin
               phase = AWAIT_HEADER;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase  = AWAIT_HEADER;
         header = '0;
         x_byte = '0;
         cur_x  = '0;
         cur_y  = '0;
         lim_x  = X_LIMIT_RESET;
         lim_y  = Y_LIMIT_RESET;
         expected_moves.delete();
      end else begin
         // results lag their third byte, so retire before predicting
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_new_x, rsp_new_y, rsp_old_x, rsp_old_y,
                    rsp_left_button, rsp_right_button, rsp_middle_button};
            if (expected_moves.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: new %0d,%0d old %0d,%0d buttons l%0d r%0d m%0d",
                           got.new_x, got.new_y, got.old_x, got.old_y,
                           got.left_btn, got.right_btn, got.middle_btn);
            end else begin
               want = expected_moves.pop_front();
               checked++;
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected new %0d,%0d old %0d,%0d buttons l%0d r%0d m%0d",
                              want.new_x, want.new_y, want.old_x, want.old_y,
                              want.left_btn, want.right_btn, want.middle_btn);
                     $display("          actual   new %0d,%0d old %0d,%0d buttons l%0d r%0d m%0d",
                              got.new_x, got.new_y, got.old_x, got.old_y,
                              got.left_btn, got.right_btn, got.middle_btn);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            track_byte(req_packet_byte);
         if (csr_we) begin
            if (csr_index == CSR_X_LIMIT)
               lim_x = csr_wdata;
            else
               lim_y = csr_wdata;
         end
      end
      error_count   <= mismatches;
      moves_pending <= expected_moves.size();
      moves_checked <= checked;
   end

endmodule

FILE: tb/tb.sv
// Testbench top for the PS/2 mouse packet tracker: byte stimulus, limit phases and verdict.
module tb;
   import ps2mt_pkg::*;

   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned ITEMS_PER_PHASE = 204;

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_packet_byte   = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b1;
   logic [POS_W-1:0]  rsp_new_x;
   logic [POS_W-1:0]  rsp_new_y;
   logic [POS_W-1:0]  rsp_old_x;
   logic [POS_W-1:0]  rsp_old_y;
   logic              rsp_left_button;
   logic              rsp_right_button;
   logic              rsp_middle_button;
   logic              csr_we            = 1'b0;
   logic              csr_index         = CSR_X_LIMIT;
   logic [POS_W-1:0]  csr_wdata         = '0;

   int unsigned error_count;
   int unsigned moves_pending;
   int unsigned moves_checked;
   int unsigned quiet_cycles   = 0;
   int unsigned bytes_accepted = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;

   logic [POS_W-1:0] x_lims [PHASES] = '{12'd1919, 12'd4095, 12'd100, 12'd0,
                                         12'd4095, 12'd0,    12'd0,   12'd639};
   logic [POS_W-1:0] y_lims [PHASES] = '{12'd1079, 12'd4095, 12'd50,  12'd0,
                                         12'd0,    12'd0,    12'd4095, 12'd479};
   int unsigned send_idle [PHASES] = '{0, 73, 0, 12, 0, 73, 0, 12};
   int unsigned rsp_stall [PHASES] = '{0, 0, 73, 12, 0, 0, 73, 12};

   // a stray byte without the sync bit first, then packets covering signs, overflows, buttons and clamps
   logic [BYTE_W-1:0] directed [25] = '{
      8'hF7,
      8'h08, 8'h05, 8'h03,
      8'h0F, 8'hFF, 8'h00,
      8'hCF, 8'h7F, 8'h00,
      8'h38, 8'h00, 8'h00,
      8'h28, 8'h00, 8'h01,
      8'hFF, 8'h01, 8'h80,
      8'h18, 8'h80, 8'hFF,
      8'h48, 8'hFF, 8'h00
   };

   ps2_mouse_packet_tracker dut (.*);

   ps2mt_scoreboard u_scoreboard (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (req_valid && req_ready && !reset)
         bytes_accepted <= bytes_accepted + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_packet_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every move has been checked and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (moves_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(input logic [POS_W-1:0] xl, input logic [POS_W-1:0] yl);
      csr_we    <= 1'b1;
      csr_index <= CSR_X_LIMIT;
      csr_wdata <= xl;
      @(posedge clock);
      csr_index <= CSR_Y_LIMIT;
      csr_wdata <= yl;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [BYTE_W-1:0] b;
      logic [POS_W-1:0]  xl;
      logic [POS_W-1:0]  yl;
      int unsigned       sent;
      int unsigned       roll;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_byte(directed[i]);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         xl = (p == 5) ? POS_W'($urandom_range(4095)) : x_lims[p];
         yl = (p == 5) ? POS_W'($urandom_range(4095)) : y_lims[p];
         set_limits(xl, yl);
         send_idle_pct = send_idle[p];
         stall_pct     = rsp_stall[p];
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            b = BYTE_W'($urandom_range(255));
            if (roll < 12) begin
               // stray byte, dropped while a header is awaited
               b[HDR_SYNC] = 1'b0;
               send_byte(b);
               sent += 1;
            end else if (roll < 17) begin
               // truncated packet: throws the framing off by one byte
               b[HDR_SYNC] = 1'b1;
               send_byte(b);
               send_byte(BYTE_W'($urandom_range(255)));
               sent += 2;
            end else begin
               b[HDR_SYNC] = 1'b1;
               send_byte(b);
               send_byte(BYTE_W'($urandom_range(255)));
               send_byte(BYTE_W'($urandom_range(255)));
               sent += 3;
            end
         end
         wait_idle();
      end

      $display("Run covered %0d bytes over %0d limit settings with mixed idling and stalls;",
               bytes_accepted, PHASES);
      $display("%0d cursor moves checked.", moves_checked);
      if (error_count == 0 && moves_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
